FILE: hdl/sorted_deadline_timer_scheduler_core_assert.svh
// Assertion macros used by the scheduler datapath
`ifndef SORTED_DEADLINE_TIMER_SCHEDULER_CORE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define SDTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdts assertion failed");

// next-cycle implication
`define SDTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdts assertion failed");

`endif

FILE: hdl/sdts_pkg.sv
// Shared types and constants of the deadline timer scheduler
package sdts_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;

  typedef enum logic [2:0] {
    OP_POLL     = 3'd0,
    OP_CREATE   = 3'd1,
    OP_RELEASE  = 3'd2,
    OP_SCHEDULE = 3'd3,
    OP_CANCEL   = 3'd4
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POLL,
    ST_REARM,
    ST_CREATE,
    ST_READ,
    ST_CHECK,
    ST_SCAN,
    ST_APPLY,
    ST_INSERT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic take;
    logic pop_head;
    logic rearm;
    logic clr_vld;
    logic grant;
    logic cnt_inc;
    logic rd_sid;
    logic rm_at_cnt;
    logic free_slot;
    logic sched;
    logic q_ins;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sid_ok;
    logic       head_due;
    logic       per_nz;
    logic       dl_nz;
    logic       cnt_free;
    logic       cnt_last;
    logic       scan_end;
    logic       scan_hit;
  } status_t;

endpackage

FILE: hdl/sdts_ctrl.sv
// Command sequencer of the deadline timer scheduler
module sdts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sdts_pkg::status_t sts_i,
  output sdts_pkg::cmd_t   cmd_o
);

  sdts_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdts_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sdts_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sdts_pkg::ST_DISPATCH;
      end
      sdts_pkg::ST_DISPATCH: begin
        case (sts_i.op)
          sdts_pkg::OP_POLL:   state_d = sdts_pkg::ST_POLL;
          sdts_pkg::OP_CREATE: state_d = sdts_pkg::ST_CREATE;
          sdts_pkg::OP_RELEASE, sdts_pkg::OP_SCHEDULE, sdts_pkg::OP_CANCEL: begin
            state_d = sts_i.sid_ok ? sdts_pkg::ST_READ : sdts_pkg::ST_DONE;
          end
          default: state_d = sdts_pkg::ST_DONE;
        endcase
      end
      sdts_pkg::ST_POLL: begin
        state_d = sts_i.head_due ? sdts_pkg::ST_REARM : sdts_pkg::ST_DONE;
      end
      sdts_pkg::ST_REARM: begin
        state_d = sts_i.per_nz ? sdts_pkg::ST_INSERT : sdts_pkg::ST_DONE;
      end
      sdts_pkg::ST_CREATE: begin
        if (sts_i.cnt_free || sts_i.cnt_last) state_d = sdts_pkg::ST_DONE;
      end
      sdts_pkg::ST_READ:  state_d = sdts_pkg::ST_CHECK;
      sdts_pkg::ST_CHECK: begin
        state_d = sts_i.dl_nz ? sdts_pkg::ST_SCAN : sdts_pkg::ST_APPLY;
      end
      sdts_pkg::ST_SCAN: begin
        if (sts_i.scan_end || sts_i.scan_hit) state_d = sdts_pkg::ST_APPLY;
      end
      sdts_pkg::ST_APPLY: begin
        state_d = (sts_i.op == sdts_pkg::OP_SCHEDULE) ? sdts_pkg::ST_INSERT
                                                       : sdts_pkg::ST_DONE;
      end
      sdts_pkg::ST_INSERT: state_d = sdts_pkg::ST_DONE;
      sdts_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = sdts_pkg::ST_IDLE;
      end
      default: state_d = sdts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      sdts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      sdts_pkg::ST_POLL: begin
        cmd_o.pop_head = sts_i.head_due;
      end
      sdts_pkg::ST_REARM: begin
        cmd_o.rearm   = sts_i.per_nz;
        cmd_o.clr_vld = !sts_i.per_nz;
      end
      sdts_pkg::ST_CREATE: begin
        cmd_o.grant   = sts_i.cnt_free;
        cmd_o.cnt_inc = !sts_i.cnt_free && !sts_i.cnt_last;
      end
      sdts_pkg::ST_READ: begin
        cmd_o.rd_sid = 1'b1;
      end
      sdts_pkg::ST_SCAN: begin
        cmd_o.rm_at_cnt = !sts_i.scan_end && sts_i.scan_hit;
        cmd_o.cnt_inc   = !sts_i.scan_end && !sts_i.scan_hit;
      end
      sdts_pkg::ST_APPLY: begin
        cmd_o.sched     = (sts_i.op == sdts_pkg::OP_SCHEDULE);
        cmd_o.clr_vld   = (sts_i.op != sdts_pkg::OP_SCHEDULE);
        cmd_o.free_slot = (sts_i.op == sdts_pkg::OP_RELEASE);
      end
      sdts_pkg::ST_INSERT: begin
        cmd_o.q_ins = 1'b1;
      end
      sdts_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/sdts_dpath.sv
// Slot store, sorted deadline queue and result register of the scheduler
`include "sorted_deadline_timer_scheduler_core_assert.svh"

module sdts_dpath #(
  parameter int unsigned NUM_TIMERS = sdts_pkg::NUM_TIMERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        opcode_i,
  input  logic [3:0]        slot_id_i,
  input  logic [31:0]       delay_ms_i,
  input  logic [31:0]       period_ms_i,
  input  logic [31:0]       now_ms_i,
  input  sdts_pkg::cmd_t    cmd_i,
  output sdts_pkg::status_t sts_o,
  output logic              fired_o,
  output logic [3:0]        fired_slot_o,
  output logic              create_ok_o,
  output logic [3:0]        created_slot_o,
  output logic [4:0]        allocated_count_o,
  output logic [4:0]        active_count_o
);

  localparam int unsigned SW = $clog2(NUM_TIMERS);
  localparam int unsigned LW = $clog2(NUM_TIMERS + 1);

  logic [2:0]        op_q;
  logic              sid_ok_q;
  logic [SW-1:0]     sid_q;
  logic [31:0]       delay_q, period_q, now_q;
  logic [SW-1:0]     s_q;
  logic [LW-1:0]     cnt_q;
  logic [SW-1:0]     cidx;
  logic              fired_q, cok_q;
  logic [SW-1:0]     cslot_q;
  logic [31:0]       ins_key_q;

  logic [31:0]       dl_mem  [NUM_TIMERS];
  logic [31:0]       per_mem [NUM_TIMERS];
  logic [31:0]       rd_dl_q, rd_per_q;
  logic              rd_vld_q;
  logic [SW-1:0]     rd_addr;
  logic              wr_en;
  logic [31:0]       wr_dl;

  logic [NUM_TIMERS-1:0] vld_q, alloc_q;
  logic [LW-1:0]     acnt_q, len_q;

  logic [31:0]       key_q [NUM_TIMERS];
  logic [31:0]       key_d [NUM_TIMERS];
  logic [SW-1:0]     qs_q  [NUM_TIMERS];
  logic [SW-1:0]     qs_d  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] gt;
  logic              q_full;

  logic              fired_oq, cok_oq;
  logic [3:0]        fslot_oq, cslot_oq;
  logic [4:0]        acnt_oq, len_oq;

  assign cidx    = cnt_q[SW-1:0];
  assign rd_addr = cmd_i.pop_head ? qs_q[0] : sid_q;
  assign wr_en   = cmd_i.rearm || cmd_i.sched;
  assign wr_dl   = cmd_i.rearm ? (now_q + rd_per_q) : (delay_q + now_q);
  assign q_full  = (len_q == LW'(NUM_TIMERS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q     <= opcode_i;
      sid_ok_q <= (32'(slot_id_i) < NUM_TIMERS);
      sid_q    <= SW'(slot_id_i);
      delay_q  <= delay_ms_i;
      period_q <= period_ms_i;
      now_q    <= now_ms_i;
    end
    if (cmd_i.pop_head || cmd_i.rd_sid) begin
      s_q      <= rd_addr;
      rd_dl_q  <= dl_mem[rd_addr];
      rd_per_q <= per_mem[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
    end
    if (wr_en) begin
      dl_mem[s_q] <= wr_dl;
      ins_key_q   <= wr_dl;
    end
    if (cmd_i.sched) per_mem[s_q] <= period_q;
    if (cmd_i.grant) cslot_q <= cidx;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      key_q[i] <= key_d[i];
      qs_q[i]  <= qs_d[i];
    end
    if (cmd_i.out_load) begin
      fired_oq <= fired_q;
      fslot_oq <= fired_q ? 4'(s_q) : 4'd0;
      cok_oq   <= cok_q;
      cslot_oq <= cok_q ? 4'(cslot_q) : 4'd0;
      acnt_oq  <= 5'(acnt_q);
      len_oq   <= 5'(len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fired_q <= 1'b0;
      cok_q   <= 1'b0;
      vld_q   <= '0;
      alloc_q <= '0;
      acnt_q  <= '0;
      len_q   <= '0;
    end else begin
      if (cmd_i.take) begin
        cnt_q   <= '0;
        fired_q <= 1'b0;
        cok_q   <= 1'b0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + LW'(1);
      end
      if (cmd_i.pop_head) fired_q <= 1'b1;
      if (wr_en) vld_q[s_q] <= 1'b1;
      if (cmd_i.clr_vld) vld_q[s_q] <= 1'b0;
      if (cmd_i.grant) begin
        cok_q         <= 1'b1;
        vld_q[cidx]   <= 1'b0;
        alloc_q[cidx] <= 1'b1;
        acnt_q        <= acnt_q + LW'(1);
      end
      if (cmd_i.free_slot && alloc_q[s_q]) begin
        alloc_q[s_q] <= 1'b0;
        acnt_q       <= acnt_q - LW'(1);
      end
      if (cmd_i.pop_head || cmd_i.rm_at_cnt) begin
        len_q <= len_q - LW'(1);
      end else if (cmd_i.q_ins && !q_full) begin
        len_q <= len_q + LW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      gt[i] = (LW'(i) < len_q) && (key_q[i] > ins_key_q);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      key_d[i] = key_q[i];
      qs_d[i]  = qs_q[i];
      if (cmd_i.pop_head || (cmd_i.rm_at_cnt && (LW'(i) >= cnt_q))) begin
        if (i < NUM_TIMERS - 1) begin
          key_d[i] = key_q[i+1];
          qs_d[i]  = qs_q[i+1];
        end
      end else if (cmd_i.q_ins && !q_full) begin
        if (i > 0 && gt[i-1]) begin
          key_d[i] = key_q[i-1];
          qs_d[i]  = qs_q[i-1];
        end else if (gt[i] || (LW'(i) == len_q)) begin
          key_d[i] = ins_key_q;
          qs_d[i]  = s_q;
        end
      end
    end
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.sid_ok   = sid_ok_q;
    sts_o.head_due = (len_q != '0) && (key_q[0] <= now_q);
    sts_o.per_nz   = rd_vld_q && (rd_per_q != '0);
    sts_o.dl_nz    = rd_vld_q && (rd_dl_q != '0);
    sts_o.cnt_free = !alloc_q[cidx];
    sts_o.cnt_last = (cnt_q == LW'(NUM_TIMERS - 1));
    sts_o.scan_end = (cnt_q >= len_q);
    sts_o.scan_hit = (key_q[cidx] == rd_dl_q) && (qs_q[cidx] == s_q);
  end

  assign fired_o           = fired_oq;
  assign fired_slot_o      = fslot_oq;
  assign create_ok_o       = cok_oq;
  assign created_slot_o    = cslot_oq;
  assign allocated_count_o = acnt_oq;
  assign active_count_o    = len_oq;

  `SDTS_ASSERT_IMP(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= LW'(NUM_TIMERS))
  `SDTS_ASSERT_IMP(a_acnt_bound, clk_i, rst_ni, 1'b1, acnt_q <= LW'(NUM_TIMERS))
  `SDTS_ASSERT_NXT(a_ins_grow, clk_i, rst_ni, cmd_i.q_ins && !q_full, len_q == $past(len_q) + LW'(1))

endmodule

FILE: hdl/sorted_deadline_timer_scheduler_core.sv
// Top level of the sorted deadline timer scheduler
// A pool of NUM_TIMERS timer slots with a deadline queue kept in ascending order of
// absolute time in a shift-register queue. One command word in gives one result word
// out; a command is taken only while the block is idle, and a finished result waits
// in an output register. Steps per command: poll checks the queue head, reads the
// slot store and re-inserts a periodic timer; create finds the lowest free slot by
// walking the allocation bits one per cycle; release, schedule and cancel walk the
// queue one entry per cycle to find the entry to remove, then schedule inserts the
// new deadline. The slot deadline and period store has one read and one write port.
// Reset needs no clearing pass.
module sorted_deadline_timer_scheduler_core #(
  parameter int unsigned NUM_TIMERS = sdts_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [3:0]  slot_id_i,
  input  logic [31:0] delay_ms_i,
  input  logic [31:0] period_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        fired_o,
  output logic [3:0]  fired_slot_o,
  output logic        create_ok_o,
  output logic [3:0]  created_slot_o,
  output logic [4:0]  allocated_count_o,
  output logic [4:0]  active_count_o
);

  sdts_pkg::cmd_t    cmd;
  sdts_pkg::status_t sts;

  sdts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sdts_dpath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .opcode_i          (opcode_i),
    .slot_id_i         (slot_id_i),
    .delay_ms_i        (delay_ms_i),
    .period_ms_i       (period_ms_i),
    .now_ms_i          (now_ms_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .fired_o           (fired_o),
    .fired_slot_o      (fired_slot_o),
    .create_ok_o       (create_ok_o),
    .created_slot_o    (created_slot_o),
    .allocated_count_o (allocated_count_o),
    .active_count_o    (active_count_o)
  );

endmodule
